@@ design/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, constants and microcode decode for the box collision scanner.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int COORD_W    = 16;
    localparam int QUAT_W     = 16;
    localparam int VEC_W      = 3 * COORD_W;
    localparam int ROT_W      = 4 * QUAT_W;
    localparam int ID_PORT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int RAM_W      = 64;
    localparam int RAM_DEPTH  = 64;
    localparam int AW         = 6;
    localparam int MUL_W      = 32;
    localparam int SRC_W      = 5;

    // Scratch memory map.
    localparam logic [AW-1:0] A_T   = 6'd0;
    localparam logic [AW-1:0] A_HA  = 6'd3;
    localparam logic [AW-1:0] A_AXA = 6'd9;
    localparam logic [AW-1:0] A_AXB = 6'd18;
    localparam logic [AW-1:0] A_QA  = 6'd27;
    localparam logic [AW-1:0] A_QB  = 6'd31;
    localparam logic [AW-1:0] A_L   = 6'd35;
    localparam logic [AW-1:0] A_SQ  = 6'd38;
    localparam logic [AW-1:0] A_D   = 6'd39;
    localparam logic [AW-1:0] A_R   = 6'd45;

    localparam int LOAD_STEPS     = 17;
    localparam int MAT_LAST_STEP  = 35;
    localparam int AXIS_LAST_STEP = 51;
    localparam int AXIS_COUNT     = 15;

    localparam logic signed [RAM_W-1:0] Q_ONE  = 64'sd16384;
    localparam logic signed [RAM_W-1:0] ONE_28 = 64'sd268435456;
    localparam logic signed [RAM_W-1:0] RND_HALF = 64'sd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND, CFG_FIRST, CFG_SECOND, CFG_ROT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OPK_NOP, OPK_LOAD, OPK_MAC, OPK_RND, OPK_ABSRND, OPK_ACC, OPK_CPY, OPK_TEST
    } t_opk;

    typedef enum logic [1:0] {
        INIT_KEEP, INIT_ZERO, INIT_ONE
    } t_init;

    typedef struct packed {
        t_opk             kind;
        t_init            init;
        logic             neg;
        logic             dbl;
        logic [AW-1:0]    ra;
        logic [AW-1:0]    rb;
        logic [AW-1:0]    dst;
        logic [SRC_W-1:0] src;
        logic             ov_en;
        logic             ov_box;
        logic             ov_diag;
    } t_uop;

    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
        t_uop op;
    } t_cmd;

    typedef struct packed {
        logic aabb_pair;
        logic item_last;
        logic out_full;
    } t_stat;

    // Round a Q28 value to Q14, half away from zero.
    function automatic logic signed [RAM_W-1:0] rnd14(input logic signed [RAM_W-1:0] v);
        logic signed [RAM_W-1:0] m;
        m = -v;
        if (v >= 0) begin
            return (v + RND_HALF) >>> 14;
        end
        return -((m + RND_HALF) >>> 14);
    endfunction

    function automatic logic signed [COORD_W-1:0] lane_c(input logic [VEC_W-1:0] v,
                                                         input int k);
        return $signed(v[k*COORD_W +: COORD_W]);
    endfunction

    function automatic logic signed [QUAT_W-1:0] lane_q(input logic [ROT_W-1:0] v,
                                                        input int k);
        return $signed(v[k*QUAT_W +: QUAT_W]);
    endfunction

    // Operand loads: t, extents of both boxes, then both quaternions.
    function automatic t_uop decode_load(input logic [AW-1:0] step);
        t_uop u;
        u = '0;
        u.kind = OPK_LOAD;
        u.src  = step[SRC_W-1:0];
        u.dst  = (step < 6'd9) ? step : step + 6'd18;
        return u;
    endfunction

    // Rotation matrix of one box: two products and one rounding per entry.
    function automatic t_uop decode_mat(input logic box, input logic [AW-1:0] step);
        t_uop u;
        logic [3:0] ent;
        logic [1:0] slot;
        logic one, n1, n2;
        logic [1:0] a1, b1, a2, b2;
        logic [AW-1:0] q;
        u    = '0;
        ent  = step[5:2];
        slot = step[1:0];
        q    = box ? A_QB : A_QA;
        one = 1'b0; n1 = 1'b0; n2 = 1'b0;
        a1 = 2'd0; b1 = 2'd0; a2 = 2'd0; b2 = 2'd0;
        // Quaternion offsets: w 0, x 1, y 2, z 3.
        case (ent)
            4'd0: begin one = 1'b1; n1 = 1'b1; a1 = 2'd2; b1 = 2'd2; n2 = 1'b1; a2 = 2'd3; b2 = 2'd3; end
            4'd1: begin a1 = 2'd1; b1 = 2'd2; a2 = 2'd0; b2 = 2'd3; end
            4'd2: begin a1 = 2'd1; b1 = 2'd3; n2 = 1'b1; a2 = 2'd0; b2 = 2'd2; end
            4'd3: begin a1 = 2'd1; b1 = 2'd2; n2 = 1'b1; a2 = 2'd0; b2 = 2'd3; end
            4'd4: begin one = 1'b1; n1 = 1'b1; a1 = 2'd1; b1 = 2'd1; n2 = 1'b1; a2 = 2'd3; b2 = 2'd3; end
            4'd5: begin a1 = 2'd2; b1 = 2'd3; a2 = 2'd0; b2 = 2'd1; end
            4'd6: begin a1 = 2'd1; b1 = 2'd3; a2 = 2'd0; b2 = 2'd2; end
            4'd7: begin a1 = 2'd2; b1 = 2'd3; n2 = 1'b1; a2 = 2'd0; b2 = 2'd1; end
            4'd8: begin one = 1'b1; n1 = 1'b1; a1 = 2'd1; b1 = 2'd1; n2 = 1'b1; a2 = 2'd2; b2 = 2'd2; end
            default: begin end
        endcase
        case (slot)
            2'd0: begin
                u.kind = OPK_MAC; u.init = one ? INIT_ONE : INIT_ZERO;
                u.neg = n1; u.dbl = 1'b1;
                u.ra = q + AW'(a1); u.rb = q + AW'(b1);
            end
            2'd1: begin
                u.kind = OPK_MAC; u.init = INIT_KEEP;
                u.neg = n2; u.dbl = 1'b1;
                u.ra = q + AW'(a2); u.rb = q + AW'(b2);
            end
            2'd2: begin
                u.kind = OPK_RND;
                u.dst = (box ? A_AXB : A_AXA) + AW'(ent);
                u.ov_en = 1'b1; u.ov_box = box;
                u.ov_diag = (ent == 4'd0) || (ent == 4'd4) || (ent == 4'd8);
            end
            default: begin end
        endcase
        return u;
    endfunction

    // One test axis: build L, its squared length, six projections, the radius
    // sum, then the projected center distance and the separation test.
    function automatic t_uop decode_axis(input logic [3:0] n, input logic [AW-1:0] step);
        t_uop u;
        logic [3:0] g;
        logic [1:0] slot;
        logic [3:0] m, ui, vi, j, r;
        logic [1:0] k, ka, kb;
        logic [AW-1:0] ub, vb;
        u    = '0;
        g    = step[5:2];
        slot = step[1:0];
        m    = n - 4'd6;
        ui   = (m >= 4'd6) ? 4'd2 : ((m >= 4'd3) ? 4'd1 : 4'd0);
        vi   = m - 4'(3 * ui);
        ub   = A_AXA + AW'(3 * ui);
        vb   = A_AXB + AW'(3 * vi);
        j    = g - 4'd4;
        r    = 4'((g - 4'd10) * 4) + 4'(slot);
        k    = g[1:0];
        ka   = 2'd1;
        kb   = 2'd2;
        case (k)
            2'd0: begin ka = 2'd1; kb = 2'd2; end
            2'd1: begin ka = 2'd2; kb = 2'd0; end
            2'd2: begin ka = 2'd0; kb = 2'd1; end
            default: begin end
        endcase
        case (g)
            4'd0, 4'd1, 4'd2: begin
                if (n < 4'd6) begin
                    if (slot == 2'd0) begin
                        u.kind = OPK_CPY;
                        u.ra = A_AXA + AW'(3 * n) + AW'(k);
                        u.dst = A_L + AW'(k);
                    end
                end else begin
                    case (slot)
                        2'd0: begin
                            u.kind = OPK_MAC; u.init = INIT_ZERO;
                            u.ra = ub + AW'(ka); u.rb = vb + AW'(kb);
                        end
                        2'd1: begin
                            u.kind = OPK_MAC; u.init = INIT_KEEP; u.neg = 1'b1;
                            u.ra = ub + AW'(kb); u.rb = vb + AW'(ka);
                        end
                        2'd2: begin
                            u.kind = OPK_RND; u.dst = A_L + AW'(k);
                        end
                        default: begin end
                    endcase
                end
            end
            4'd3: begin
                if (slot == 2'd3) begin
                    u.kind = OPK_ACC; u.dst = A_SQ;
                end else begin
                    u.kind = OPK_MAC;
                    u.init = (slot == 2'd0) ? INIT_ZERO : INIT_KEEP;
                    u.ra = A_L + AW'(slot); u.rb = A_L + AW'(slot);
                end
            end
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: begin
                if (slot == 2'd3) begin
                    u.kind = OPK_ABSRND; u.dst = A_D + AW'(j);
                end else begin
                    u.kind = OPK_MAC;
                    u.init = (slot == 2'd0) ? INIT_ZERO : INIT_KEEP;
                    u.ra = A_AXA + AW'(3 * j) + AW'(slot);
                    u.rb = A_L + AW'(slot);
                end
            end
            4'd10, 4'd11: begin
                if (r < 4'd6) begin
                    u.kind = OPK_MAC;
                    u.init = (r == 4'd0) ? INIT_ZERO : INIT_KEEP;
                    u.ra = A_HA + AW'(r); u.rb = A_D + AW'(r);
                end else if (r == 4'd6) begin
                    u.kind = OPK_ACC; u.dst = A_R;
                end
            end
            4'd12: begin
                if (slot == 2'd3) begin
                    u.kind = OPK_TEST; u.ra = A_R; u.rb = A_SQ;
                end else begin
                    u.kind = OPK_MAC;
                    u.init = (slot == 2'd0) ? INIT_ZERO : INIT_KEEP;
                    u.ra = A_T + AW'(slot); u.rb = A_L + AW'(slot);
                end
            end
            default: begin end
        endcase
        return u;
    endfunction

endpackage

@@ design/bcs_ram.sv @@
// ----------------------------------------------------------------------------
// bcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcs_ctrl
// Sequencer: walks operand load, matrix build and the fifteen axis programs.
// ----------------------------------------------------------------------------
module bcs_ctrl
    import bcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_LOAD, S_MAT, S_AXIS, S_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_sub, n_sub;
    logic [AW-1:0] r_step, n_step;
    logic [3:0]    r_outer, n_outer;

    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_step  = r_step;
        n_outer = r_outer;
        o_cmd         = '0;
        o_cmd.capture = i_accept;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_CHECK;
                    n_sub   = 2'd0;
                    n_step  = '0;
                    n_outer = '0;
                end
            end
            S_CHECK: begin
                n_state = i_stat.aabb_pair ? S_FIN : S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = decode_load(r_step);
                if (r_sub == 2'd2) begin
                    o_cmd.exec = 1'b1;
                    n_sub = 2'd0;
                    if (r_step == AW'(LOAD_STEPS - 1)) begin
                        n_step  = '0;
                        n_state = S_MAT;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end else begin
                    n_sub = r_sub + 1'b1;
                end
            end
            S_MAT: begin
                o_cmd.op = decode_mat(r_outer[0], r_step);
                if (r_sub == 2'd2) begin
                    o_cmd.exec = 1'b1;
                    n_sub = 2'd0;
                    if (r_step == AW'(MAT_LAST_STEP)) begin
                        n_step = '0;
                        if (r_outer[0]) begin
                            n_outer = '0;
                            n_state = S_AXIS;
                        end else begin
                            n_outer = 4'd1;
                        end
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end else begin
                    n_sub = r_sub + 1'b1;
                end
            end
            S_AXIS: begin
                o_cmd.op = decode_axis(r_outer, r_step);
                if (r_sub == 2'd2) begin
                    o_cmd.exec = 1'b1;
                    n_sub = 2'd0;
                    if (r_step == AW'(AXIS_LAST_STEP)) begin
                        n_step = '0;
                        if (r_outer == 4'(AXIS_COUNT - 1)) begin
                            n_state = S_FIN;
                        end else begin
                            n_outer = r_outer + 1'b1;
                        end
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end else begin
                    n_sub = r_sub + 1'b1;
                end
            end
            S_FIN: begin
                // A closing word waits for the output register to drain.
                if (!i_stat.item_last || !i_stat.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sub   <= '0;
            r_step  <= '0;
            r_outer <= '0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_step  <= n_step;
            r_outer <= n_outer;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ design/bcs_dp.sv @@
// ----------------------------------------------------------------------------
// bcs_dp
// Datapath: configuration and item registers, scratch memory, shared
// multiplier with accumulator, hit tracking and the result register.
// ----------------------------------------------------------------------------
module bcs_dp
    import bcs_pkg::*;
#(
    parameter int IDENT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_kind,
    input  logic [VEC_W-1:0]      i_first,
    input  logic [VEC_W-1:0]      i_second,
    input  logic [ROT_W-1:0]      i_rot,
    input  logic [ID_PORT_W-1:0]  i_ident,
    input  logic                  i_last,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_out_collided,
    output logic [ID_PORT_W-1:0]  o_out_ident
);

    localparam int KW = (IDENT_WIDTH < ID_PORT_W) ? IDENT_WIDTH : ID_PORT_W;

    logic                 r_ckind;
    logic [VEC_W-1:0]     r_cfirst, r_csecond;
    logic [ROT_W-1:0]     r_crot;
    logic                 r_ekind, r_elast;
    logic [VEC_W-1:0]     r_efirst, r_esecond;
    logic [ROT_W-1:0]     r_erot;
    logic [KW-1:0]        r_eid;

    logic                 r_sep;
    logic                 r_hit_seen;
    logic [KW-1:0]        r_hit_id;
    logic                 r_out_valid;
    logic                 r_out_coll;
    logic [KW-1:0]        r_out_id;

    logic signed [RAM_W-1:0] r_acc, r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ckind   <= 1'b0;
            r_cfirst  <= '0;
            r_csecond <= '0;
            r_crot    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KIND:   r_ckind   <= i_cfg_data[0];
                CFG_FIRST:  r_cfirst  <= i_cfg_data[VEC_W-1:0];
                CFG_SECOND: r_csecond <= i_cfg_data[VEC_W-1:0];
                CFG_ROT:    r_crot    <= i_cfg_data[ROT_W-1:0];
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ekind   <= i_kind;
            r_efirst  <= i_first;
            r_esecond <= i_second;
            r_erot    <= i_rot;
            r_eid     <= i_ident[KW-1:0];
            r_elast   <= i_last;
        end
    end

    // Box operands, doubled so that no halving is needed.
    logic both_or, use_abs, aabb_pair, aabb_hit;
    logic signed [COORD_W-1:0] ap [3], aq [3], bp [3], bq [3];
    logic signed [COORD_W+1:0] ca [3], ha [3], cb [3], hb [3], hma [3], hmb [3];
    logic signed [COORD_W+2:0] tv [3];

    assign both_or   = r_ckind & r_ekind;
    assign use_abs   = !both_or;
    assign aabb_pair = !r_ckind && !r_ekind;

    always_comb begin
        aabb_hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            ap[k] = lane_c(r_cfirst, k);
            aq[k] = lane_c(r_csecond, k);
            bp[k] = lane_c(r_efirst, k);
            bq[k] = lane_c(r_esecond, k);
            ca[k] = r_ckind ? ((COORD_W+2)'(ap[k]) <<< 1)
                            : ((COORD_W+2)'(ap[k]) + (COORD_W+2)'(aq[k]));
            ha[k] = r_ckind ? ((COORD_W+2)'(aq[k]) <<< 1)
                            : ((COORD_W+2)'(aq[k]) - (COORD_W+2)'(ap[k]));
            cb[k] = r_ekind ? ((COORD_W+2)'(bp[k]) <<< 1)
                            : ((COORD_W+2)'(bp[k]) + (COORD_W+2)'(bq[k]));
            hb[k] = r_ekind ? ((COORD_W+2)'(bq[k]) <<< 1)
                            : ((COORD_W+2)'(bq[k]) - (COORD_W+2)'(bp[k]));
            hma[k] = (use_abs && ha[k] < 0) ? -ha[k] : ha[k];
            hmb[k] = (use_abs && hb[k] < 0) ? -hb[k] : hb[k];
            tv[k]  = (COORD_W+3)'(cb[k]) - (COORD_W+3)'(ca[k]);
            if (!(ap[k] <= bq[k] && aq[k] >= bp[k])) begin
                aabb_hit = 1'b0;
            end
        end
    end

    logic signed [RAM_W-1:0] src_val;

    always_comb begin
        case (i_cmd.op.src)
            5'd0:  src_val = RAM_W'(tv[0]);
            5'd1:  src_val = RAM_W'(tv[1]);
            5'd2:  src_val = RAM_W'(tv[2]);
            5'd3:  src_val = RAM_W'(hma[0]);
            5'd4:  src_val = RAM_W'(hma[1]);
            5'd5:  src_val = RAM_W'(hma[2]);
            5'd6:  src_val = RAM_W'(hmb[0]);
            5'd7:  src_val = RAM_W'(hmb[1]);
            5'd8:  src_val = RAM_W'(hmb[2]);
            5'd9:  src_val = RAM_W'(lane_q(r_crot, 0));
            5'd10: src_val = RAM_W'(lane_q(r_crot, 1));
            5'd11: src_val = RAM_W'(lane_q(r_crot, 2));
            5'd12: src_val = RAM_W'(lane_q(r_crot, 3));
            5'd13: src_val = RAM_W'(lane_q(r_erot, 0));
            5'd14: src_val = RAM_W'(lane_q(r_erot, 1));
            5'd15: src_val = RAM_W'(lane_q(r_erot, 2));
            5'd16: src_val = RAM_W'(lane_q(r_erot, 3));
            default: src_val = '0;
        endcase
    end

    // Scratch memory: two copies give two read ports.
    logic             ram_we;
    logic [RAM_W-1:0] ram_wdata, ra_q, rb_q;

    bcs_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.op.dst),
        .i_wdata (ram_wdata),
        .i_raddr (i_cmd.op.ra),
        .o_rdata (ra_q)
    );

    bcs_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.op.dst),
        .i_wdata (ram_wdata),
        .i_raddr (i_cmd.op.rb),
        .o_rdata (rb_q)
    );

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [RAM_W-1:0] mul_p, term, base, rnd_v, rnd_abs, acc_abs;
    logic signed [RAM_W-1:0] min_sq;
    logic                    ov_aligned;

    assign mul_a = $signed(ra_q[MUL_W-1:0]);
    assign mul_b = $signed(rb_q[MUL_W-1:0]);
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    always_comb begin
        term = i_cmd.op.dbl ? (r_prod <<< 1) : r_prod;
        if (i_cmd.op.neg) begin
            term = -term;
        end
        case (i_cmd.op.init)
            INIT_ZERO: base = '0;
            INIT_ONE:  base = ONE_28;
            default:   base = r_acc;
        endcase
        rnd_v   = rnd14(r_acc);
        rnd_abs = (rnd_v < 0) ? -rnd_v : rnd_v;
        acc_abs = (r_acc < 0) ? -r_acc : r_acc;
        min_sq  = both_or ? 64'sd1 : 64'sd3;
        ov_aligned = i_cmd.op.ov_en && !(i_cmd.op.ov_box ? r_ekind : r_ckind);
        ram_we    = 1'b0;
        ram_wdata = '0;
        case (i_cmd.op.kind)
            OPK_LOAD: begin
                ram_we = i_cmd.exec; ram_wdata = src_val;
            end
            OPK_RND: begin
                ram_we = i_cmd.exec;
                if (ov_aligned) begin
                    ram_wdata = i_cmd.op.ov_diag ? Q_ONE : '0;
                end else begin
                    ram_wdata = rnd_v;
                end
            end
            OPK_ABSRND: begin
                ram_we = i_cmd.exec; ram_wdata = rnd_abs;
            end
            OPK_ACC: begin
                ram_we = i_cmd.exec; ram_wdata = r_acc;
            end
            OPK_CPY: begin
                ram_we = i_cmd.exec; ram_wdata = ra_q;
            end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_cmd.op.kind == OPK_MAC) begin
            r_acc <= base + term;
        end
    end

    // Hit tracking and the result register.
    logic          hit_now, seen_n;
    logic [KW-1:0] id_n;

    assign hit_now = aabb_pair ? aabb_hit : !r_sep;
    assign seen_n  = r_hit_seen | hit_now;
    assign id_n    = r_hit_seen ? r_hit_id : (hit_now ? r_eid : r_hit_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep       <= 1'b0;
            r_hit_seen  <= 1'b0;
            r_hit_id    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_sep <= 1'b0;
            end else if (i_cmd.exec && i_cmd.op.kind == OPK_TEST) begin
                if ($signed(rb_q) >= min_sq && acc_abs > $signed(ra_q)) begin
                    r_sep <= 1'b1;
                end
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_elast) begin
                    r_out_valid <= 1'b1;
                    r_hit_seen  <= 1'b0;
                    r_hit_id    <= '0;
                end else begin
                    r_hit_seen <= seen_n;
                    r_hit_id   <= id_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_elast) begin
            r_out_coll <= seen_n;
            r_out_id   <= seen_n ? id_n : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_collided = r_out_coll;
    assign o_out_ident    = ID_PORT_W'(r_out_id);

    assign o_stat.aabb_pair = aabb_pair;
    assign o_stat.item_last = r_elast;
    assign o_stat.out_full  = r_out_valid;

endmodule

@@ design/box_collision_scan.sv @@
// ----------------------------------------------------------------------------
// box_collision_scan
// Tests a stream of scene boxes against one configured interactor box.
// ----------------------------------------------------------------------------
// Usage: write the interactor through the configuration channel (index 0 kind,
// 1 first vector, 2 second vector, 3 rotation) while the block is idle. Scene
// boxes then arrive as words on the s_axis channel; the word with tlast set
// closes a query and produces one result word on m_axis: bit 0 says whether
// any box of the query intersected, bits 16:1 carry the id of the first one.
// Words without tlast produce no result.
// Flow: one word is taken at a time. A pair of axis-aligned boxes goes from
// the check state straight to the closing state, which records its outcome.
// Any pair with an oriented box runs a microcoded program on one shared
// 32x32 multiplier: 17 operand loads, 72 matrix steps and 15 axes of 52 steps,
// each step a scratch read, a multiply and an accumulate. A check state comes
// before the loads and a closing state follows the last axis.
// The result register decouples the output: the next word is accepted while a
// result waits. If the receiver stalls, a following tlast word waits at its
// end until the previous result is taken.
// Reset clears the configuration, the pending hit and the output valid flag.
// ----------------------------------------------------------------------------
module box_collision_scan
    import bcs_pkg::*;
#(
    parameter int IDENT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Scene box stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // element_first_vec [47:0], element_second_vec [95:48],
    // element_rotation [159:96], element_ident [175:160]
    input  logic [175:0]          s_axis_tdata,
    // element_kind [0]
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // collided [0], collided_ident [16:1], zero [23:17]
    output logic [23:0]           m_axis_tdata
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_accept;
    logic  out_coll;
    logic [ID_PORT_W-1:0] out_id;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = s_axis_tvalid && s_axis_tready;

    bcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .o_ready  (s_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    bcs_dp #(.IDENT_WIDTH(IDENT_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (s_axis_tuser),
        .i_first        (s_axis_tdata[47:0]),
        .i_second       (s_axis_tdata[95:48]),
        .i_rot          (s_axis_tdata[159:96]),
        .i_ident        (s_axis_tdata[175:160]),
        .i_last         (s_axis_tlast),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_collided (out_coll),
        .o_out_ident    (out_id)
    );

    assign m_axis_tdata = {7'b0, out_id, out_coll};

endmodule
